@@ rtl/vkf_pkg.sv @@
// Shared types, codes and sizes for the three-axis velocity Kalman filter.
`default_nettype none

package vkf_pkg;

  // Number of filtered axes; the request carries three axis fields.
  localparam int unsigned AXES       = 3;
  localparam int unsigned AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned FIELD_AXES = 3;

  // Datapath sizes
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned DIV_DVD_W = 65;
  localparam int unsigned DIV_DVS_W = 33;
  localparam int unsigned DIV_Q_W   = 33;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned CFG_IDX_W = 3;

  // Register reset values
  localparam logic [31:0] INIT_VAR_RST = 32'h0001_0000;
  localparam logic [31:0] MAX_DT_RST   = 32'd1677722;

  typedef enum logic [1:0] {
    CMD_PREDICT = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_VAR    = 3'd0,
    REG_PROC_NOISE  = 3'd1,
    REG_ACCEL_NOISE = 3'd2,
    REG_MIN_DT      = 3'd3,
    REG_MAX_DT      = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_P_M1,
    ST_P_M2,
    ST_P_M3,
    ST_P_M4,
    ST_P_M5,
    ST_P_PV,
    ST_P_AXM,
    ST_P_AXU,
    ST_U_DIFF,
    ST_U_M1,
    ST_U_M2,
    ST_U_M3,
    ST_U_D1,
    ST_U_S2,
    ST_U_D2,
    ST_DONE
  } st_e;

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/velocity_kalman_filter_3axis_core.sv @@
// Three-axis velocity Kalman filter: sequencer, state and output register.
//
// Usage: one request per command (predict, update, clear, load) on the
// in_valid_i/in_ready_o channel; each request yields exactly one result on
// out_valid_o/out_ready_i holding the velocity, per-axis variance and the
// initialized flag after the step. Configuration registers are written via
// cfg_we_i/cfg_idx_i/cfg_data_i with no wait; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// Clear, load, update-while-uninitialized and predict with dt at or below
// min_dt go straight to the result; update otherwise runs the bit-serial
// divider twice per axis, for the gain correction and the new variance.
// A shared registered 32x32 multiplier does every product. One request is
// processed at a time; in_ready_o is high only while the sequencer is idle.
// A finished result sits in an output register, so the next request is
// accepted while it waits; a second result holds the sequencer until the
// first one is taken. Reset clears the velocities and the flag, loads the
// default registers and sets every variance to the initial variance; no
// result is pending after reset.
`default_nettype none

module velocity_kalman_filter_3axis_core import vkf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           command_i,
  input  wire logic signed [31:0]   accel_x_i,
  input  wire logic signed [31:0]   accel_y_i,
  input  wire logic signed [31:0]   accel_z_i,
  input  wire logic [31:0]          step_time_i,
  input  wire logic signed [31:0]   meas_x_i,
  input  wire logic signed [31:0]   meas_y_i,
  input  wire logic signed [31:0]   meas_z_i,
  input  wire logic [31:0]          meas_noise_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [31:0]        vel_x_o,
  output logic signed [31:0]        vel_y_o,
  output logic signed [31:0]        vel_z_o,
  output logic [31:0]               var_x_o,
  output logic [31:0]               var_y_o,
  output logic [31:0]               var_z_o,
  output logic                      is_initialized_o
);

  // Clamp a wide signed sum to 32 bits
  function automatic logic signed [31:0] sat_s32(input logic signed [41:0] v);
    if (v[41:31] == {11{v[41]}}) return v[31:0];
    else if (v[41]) return 32'sh8000_0000;
    else return 32'sh7FFF_FFFF;
  endfunction

  // Configuration registers
  logic [31:0] init_var_q, pnoise_q, anoise_q, min_dt_q, max_dt_q;
  logic [31:0] init_var_fl;

  // Filter state
  logic signed [31:0] vel_q [AXES];
  logic [31:0]        var_q [AXES];
  logic               flag_q;

  // Sequencer
  st_e               st_q, st_d;
  logic [AXIS_W-1:0] axis_q;
  logic              last_axis;

  // Captured request
  cmd_e               cmd_q;
  logic signed [31:0] acc_q  [AXES];
  logic signed [31:0] meas_q [AXES];
  logic [31:0]        dt_q, r_q;

  // Working registers
  logic [39:0] p1_q, a_q;
  logic [63:0] lo_q, rp_q;
  logic [71:0] sum_q;
  logic [31:0] pv_q, p_q;
  logic [32:0] mag_q, den_q;
  logic        neg_q;

  // Output register
  logic signed [31:0] vel_o_q [AXES];
  logic [31:0]        var_o_q [AXES];
  logic               init_o_q, out_valid_q, out_free;

  // Shared units
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  vkf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  vkf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Request fields per axis, missing axes read as zero
  logic signed [31:0] acc_f [FIELD_AXES];
  logic signed [31:0] meas_f [FIELD_AXES];
  logic signed [31:0] acc_in [AXES];
  logic signed [31:0] meas_in [AXES];

  assign acc_f[0]  = accel_x_i;
  assign acc_f[1]  = accel_y_i;
  assign acc_f[2]  = accel_z_i;
  assign meas_f[0] = meas_x_i;
  assign meas_f[1] = meas_y_i;
  assign meas_f[2] = meas_z_i;

  for (genvar g = 0; g < AXES; g++) begin : g_in
    if (g < FIELD_AXES) begin : g_field
      assign acc_in[g]  = acc_f[g];
      assign meas_in[g] = meas_f[g];
    end else begin : g_zero
      assign acc_in[g]  = '0;
      assign meas_in[g] = '0;
    end
  end

  assign init_var_fl = (init_var_q == '0) ? 32'd1 : init_var_q;
  assign last_axis   = (axis_q == AXIS_W'(AXES - 1));
  assign out_free    = !out_valid_q || out_ready_i;

  // dt gating and clipping
  logic        dt_le_min;
  logic [31:0] dt_top, dt_clip;
  assign dt_le_min = (dt_q <= min_dt_q);
  assign dt_top    = (max_dt_q > min_dt_q) ? max_dt_q : min_dt_q;
  assign dt_clip   = (dt_q > dt_top) ? dt_top : dt_q;

  // Process variance from the accumulated products
  logic [31:0] p2;
  logic [40:0] pv_sum;
  logic [31:0] pv_d;
  assign p2     = (sum_q[71:56] != '0) ? 32'hFFFF_FFFF : sum_q[55:24];
  assign pv_sum = {1'b0, p1_q} + {9'b0, p2};
  assign pv_d   = (pv_sum[40:32] != '0) ? 32'hFFFF_FFFF : pv_sum[31:0];

  // Predict per axis: acceleration magnitude, velocity and variance
  logic signed [31:0] acc_cur;
  logic [31:0]        acc_mag;
  logic [41:0]        dv;
  logic signed [31:0] vel_axu;
  logic [32:0]        var_sum;
  logic [31:0]        var_axu;
  assign acc_cur = acc_q[axis_q];
  assign acc_mag = acc_cur[31] ? (~acc_cur + 32'd1) : acc_cur;
  assign dv      = acc_cur[31] ? -{2'b0, prod[63:24]} : {2'b0, prod[63:24]};
  assign vel_axu = sat_s32({{10{vel_q[axis_q][31]}}, vel_q[axis_q]} + $signed(dv));
  assign var_sum = {1'b0, var_q[axis_q]} + {1'b0, pv_q};
  assign var_axu = var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];

  // Update per axis: innovation, prior variance and gain denominator
  logic [32:0] diff, mag_d;
  logic [31:0] p_sel;
  logic [32:0] den_d;
  assign diff  = {meas_q[axis_q][31], meas_q[axis_q]} - {vel_q[axis_q][31], vel_q[axis_q]};
  assign mag_d = diff[32] ? -diff : diff;
  assign p_sel = (var_q[axis_q] == '0) ? 32'd1 : var_q[axis_q];
  assign den_d = {1'b0, p_sel} + {1'b0, r_q};

  // Update results from the divider
  logic [41:0]        dc;
  logic signed [31:0] vel_upd;
  logic [31:0]        var_upd;
  assign dc      = neg_q ? -{9'b0, div_rsp.quotient} : {9'b0, div_rsp.quotient};
  assign vel_upd = sat_s32({{10{vel_q[axis_q][31]}}, vel_q[axis_q]} + $signed(dc));
  assign var_upd = (div_rsp.quotient[31:0] == '0) ? 32'd1 : div_rsp.quotient[31:0];

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (in_valid_i) st_d = ST_START;
      ST_START: begin
        unique case (cmd_q)
          CMD_PREDICT: st_d = dt_le_min ? ST_DONE : ST_P_M1;
          CMD_UPDATE:  st_d = flag_q ? ST_U_DIFF : ST_DONE;
          default:     st_d = ST_DONE;
        endcase
      end
      ST_P_M1:   st_d = ST_P_M2;
      ST_P_M2:   st_d = ST_P_M3;
      ST_P_M3:   st_d = ST_P_M4;
      ST_P_M4:   st_d = ST_P_M5;
      ST_P_M5:   st_d = ST_P_PV;
      ST_P_PV:   st_d = ST_P_AXM;
      ST_P_AXM:  st_d = ST_P_AXU;
      ST_P_AXU:  st_d = last_axis ? ST_DONE : ST_P_AXM;
      ST_U_DIFF: st_d = ST_U_M1;
      ST_U_M1:   st_d = ST_U_M2;
      ST_U_M2:   st_d = ST_U_M3;
      ST_U_M3:   st_d = ST_U_D1;
      ST_U_D1:   if (div_rsp.done) st_d = ST_U_S2;
      ST_U_S2:   st_d = ST_U_D2;
      ST_U_D2:   if (div_rsp.done) st_d = last_axis ? ST_DONE : ST_U_DIFF;
      ST_DONE:   if (out_free) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands, divider requests
  always_comb begin
    in_ready_o       = (st_q == ST_IDLE);
    mul_a            = '0;
    mul_b            = dt_q;
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, rp_q};
    div_req.divisor  = den_q;
    unique case (st_q)
      ST_P_M1:  mul_a = pnoise_q;
      ST_P_M2:  mul_a = anoise_q;
      ST_P_M3:  mul_a = prod[55:24];
      ST_P_M4:  mul_a = {24'b0, a_q[39:32]};
      ST_P_AXM: mul_a = acc_mag;
      ST_U_M1: begin
        mul_a = mag_q[31:0];
        mul_b = p_q;
      end
      ST_U_M2: begin
        mul_a            = r_q;
        mul_b            = p_q;
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, prod} + (mag_q[32] ? {1'b0, p_q, 32'b0} : 65'd0);
      end
      ST_U_S2:  div_req.start = 1'b1;
      default: ;
    endcase
  end

  // Control, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      axis_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      init_var_q  <= INIT_VAR_RST;
      pnoise_q    <= '0;
      anoise_q    <= '0;
      min_dt_q    <= '0;
      max_dt_q    <= MAX_DT_RST;
      for (int i = 0; i < AXES; i++) begin
        vel_q[i] <= '0;
        var_q[i] <= INIT_VAR_RST;
      end
    end else begin
      st_q <= st_d;

      // register writes
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_INIT_VAR: begin
            init_var_q <= cfg_data_i;
            if (!flag_q) begin
              for (int i = 0; i < AXES; i++) begin
                var_q[i] <= (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
              end
            end
          end
          REG_PROC_NOISE:  pnoise_q <= cfg_data_i;
          REG_ACCEL_NOISE: anoise_q <= cfg_data_i;
          REG_MIN_DT:      min_dt_q <= cfg_data_i;
          REG_MAX_DT:      max_dt_q <= cfg_data_i;
          default: ;
        endcase
      end

      // result handshake
      if (st_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_START: begin
          axis_q <= '0;
          unique case (cmd_q)
            CMD_PREDICT: begin
              if (!flag_q) begin
                for (int i = 0; i < AXES; i++) begin
                  vel_q[i] <= '0;
                  var_q[i] <= init_var_fl;
                end
              end
            end
            CMD_UPDATE: begin
              if (!flag_q) begin
                flag_q <= 1'b1;
                for (int i = 0; i < AXES; i++) begin
                  vel_q[i] <= meas_q[i];
                  var_q[i] <= init_var_fl;
                end
              end
            end
            CMD_CLEAR: begin
              flag_q <= 1'b0;
              for (int i = 0; i < AXES; i++) begin
                vel_q[i] <= '0;
                var_q[i] <= init_var_fl;
              end
            end
            CMD_LOAD: begin
              flag_q <= 1'b1;
              for (int i = 0; i < AXES; i++) begin
                vel_q[i] <= meas_q[i];
                var_q[i] <= init_var_fl;
              end
            end
            default: ;
          endcase
        end
        ST_P_AXU: begin
          vel_q[axis_q] <= vel_axu;
          var_q[axis_q] <= var_axu;
          if (!last_axis) axis_q <= axis_q + AXIS_W'(1);
        end
        ST_U_D1: begin
          if (div_rsp.done) vel_q[axis_q] <= vel_upd;
        end
        ST_U_D2: begin
          if (div_rsp.done) begin
            var_q[axis_q] <= var_upd;
            if (!last_axis) axis_q <= axis_q + AXIS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Request capture and working registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_e'(command_i);
      dt_q  <= step_time_i;
      r_q   <= (meas_noise_i == '0) ? 32'd1 : meas_noise_i;
      for (int i = 0; i < AXES; i++) begin
        acc_q[i]  <= acc_in[i];
        meas_q[i] <= meas_in[i];
      end
    end else if (st_q == ST_START) begin
      dt_q <= dt_clip;
    end

    unique case (st_q)
      ST_P_M2: p1_q  <= prod[63:24];
      ST_P_M3: a_q   <= prod[63:24];
      ST_P_M4: lo_q  <= prod;
      ST_P_M5: sum_q <= {8'b0, lo_q} + {prod[39:0], 32'b0};
      ST_P_PV: pv_q  <= pv_d;
      ST_U_DIFF: begin
        mag_q <= mag_d;
        neg_q <= diff[32];
        p_q   <= p_sel;
        den_q <= den_d;
      end
      ST_U_M3: rp_q <= prod;
      ST_DONE: begin
        if (out_free) begin
          init_o_q <= flag_q;
          for (int i = 0; i < AXES; i++) begin
            vel_o_q[i] <= vel_q[i];
            var_o_q[i] <= var_q[i];
          end
        end
      end
      default: ;
    endcase
  end

  // Result ports, absent axes report velocity 0 and variance 1
  logic signed [31:0] vel_f [FIELD_AXES];
  logic [31:0]        var_f [FIELD_AXES];

  for (genvar g = 0; g < FIELD_AXES; g++) begin : g_out
    if (g < AXES) begin : g_used
      assign vel_f[g] = vel_o_q[g];
      assign var_f[g] = var_o_q[g];
    end else begin : g_pad
      assign vel_f[g] = '0;
      assign var_f[g] = 32'd1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign vel_x_o          = vel_f[0];
  assign vel_y_o          = vel_f[1];
  assign vel_z_o          = vel_f[2];
  assign var_x_o          = var_f[0];
  assign var_y_o          = var_f[1];
  assign var_z_o          = var_f[2];
  assign is_initialized_o = init_o_q;

  // Variances never drop to zero in a delivered result
  a_var_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (var_x_o != '0) && (var_y_o != '0) && (var_z_o != '0))
    else $error("zero variance in result");

  // The new variance always fits 32 bits
  a_var_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_U_D2) && div_rsp.done |-> !div_rsp.quotient[DIV_Q_W-1])
    else $error("variance quotient overflow");

  // A result only appears out of the final state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == ST_DONE))
    else $error("result raised outside done state");

  // An accepted request starts its command decode next cycle
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> st_q == ST_START)
    else $error("accepted request not started");

endmodule

`default_nettype wire

@@ rtl/vkf_mul.sv @@
// Registered 32x32 unsigned multiplier shared by all filter steps.
`default_nettype none

module vkf_mul import vkf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [MUL_W-1:0]     a_i,
  input  wire logic [MUL_W-1:0]     b_i,
  output logic      [2*MUL_W-1:0]   prod_o
);

  logic [2*MUL_W-1:0] prod_q;

  // One product per cycle, registered so the result appears in the next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= (2*MUL_W)'(a_i) * (2*MUL_W)'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ rtl/vkf_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module vkf_div import vkf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DVS_W-1:0] rem_q, dvs_q;
  logic [DIV_Q_W-1:0]   low_q;

  logic [DIV_DVS_W:0]   trial, diff;
  logic                 ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem_q, low_q[DIV_Q_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  // Control: quotient fits DIV_Q_W bits, so DIV_Q_W steps suffice
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= DIV_DVS_W'(req_i.dividend[DIV_DVD_W-1:DIV_Q_W]);
      low_q <= req_i.dividend[DIV_Q_W-1:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
      low_q <= {low_q[DIV_Q_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = low_q;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the three-axis velocity Kalman filter core.
`default_nettype none

module testbench;
  import vkf_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 6;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 170;
  localparam int HOLD_CYCLES  = 800;
  localparam int TAIL_CYCLES  = 250;
  localparam int LIMIT_CYCLES = 2_500_000;
  localparam int HOLD_PHASE   = 5;

  localparam logic [31:0] UNIT_Q16  = 32'h0001_0000;  // 1.0 in Q16.16
  localparam logic [31:0] DT_1S     = 32'h0100_0000;  // 1 s in Q8.24
  localparam logic [31:0] DT_200MS  = 32'd3355444;
  localparam logic [31:0] DT_50MS   = 32'd838861;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX   = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    cmd_e             command;
    logic [2:0][31:0] accel;
    logic [31:0]      step_time;
    logic [2:0][31:0] meas;
    logic [31:0]      meas_noise;
  } filter_request_t;

  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0][31:0] variance;
    logic             initialized;
  } filter_state_t;

  typedef struct {
    filter_request_t req;
    bit              typed;
    filter_state_t   want;
  } directed_row_t;

  // DUT connections
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           command_i;
  logic signed [31:0]   accel_x_i, accel_y_i, accel_z_i;
  logic [31:0]          step_time_i;
  logic signed [31:0]   meas_x_i, meas_y_i, meas_z_i;
  logic [31:0]          meas_noise_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [31:0]   vel_x_o, vel_y_o, vel_z_o;
  logic [31:0]          var_x_o, var_y_o, var_z_o;
  logic                 is_initialized_o;

  // Register mirror and filter estimate
  logic [31:0]        cfg_init_var, cfg_proc_noise, cfg_accel_noise, cfg_min_dt, cfg_max_dt;
  logic signed [31:0] est_vel [3];
  logic [31:0]        est_var [3];
  logic               est_ready;

  filter_state_t pending_results[$];
  directed_row_t directed_tab[$];
  filter_state_t popped_state;
  int            err_count = 0;

  // Receiver pacing
  bit calm        = 1'b0;
  bit hold_request = 1'b0;
  bit hold_taken  = 1'b0;
  int hold_left   = 0;
  int stall_left  = 0;
  int run_left    = 0;
  logic next_ready;

  velocity_kalman_filter_3axis_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .step_time_i     (step_time_i),
    .meas_x_i        (meas_x_i),
    .meas_y_i        (meas_y_i),
    .meas_z_i        (meas_z_i),
    .meas_noise_i    (meas_noise_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .vel_x_o         (vel_x_o),
    .vel_y_o         (vel_y_o),
    .vel_z_o         (vel_z_o),
    .var_x_o         (var_x_o),
    .var_y_o         (var_y_o),
    .var_z_o         (var_z_o),
    .is_initialized_o(is_initialized_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] floored_init_var();
    return (cfg_init_var == 32'd0) ? 32'd1 : cfg_init_var;
  endfunction

  function automatic logic [31:0] sat_word(logic signed [63:0] v);
    if (v > S32_MAX) return POS_MAX;
    if (v < S32_MIN) return NEG_MAX;
    return v[31:0];
  endfunction

  // acc * dt >> 24, truncated toward zero
  function automatic logic signed [63:0] scale_by_dt(logic signed [31:0] acc, logic [31:0] dt);
    logic signed [63:0] wide;
    logic [63:0]        mag;
    logic [63:0]        q;
    wide = acc;
    mag  = (wide < 0) ? -wide : wide;
    q    = (mag * {32'd0, dt}) >> 24;
    return (wide < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic void reset_axes(bit use_meas, filter_request_t rq);
    for (int i = 0; i < 3; i++) begin
      est_vel[i] = use_meas ? rq.meas[i] : 32'd0;
      est_var[i] = floored_init_var();
    end
  endfunction

  function automatic void predict_step(filter_request_t rq);
    logic [31:0]        dt, top;
    logic [63:0]        p1, a, pv, nv;
    logic [127:0]       p2;
    logic signed [63:0] v64;
    dt  = rq.step_time;
    top = (cfg_max_dt > cfg_min_dt) ? cfg_max_dt : cfg_min_dt;
    // an uninitialized filter is cleared before it integrates
    if (!est_ready) reset_axes(1'b0, rq);
    if (dt <= cfg_min_dt) return;
    if (dt > top) dt = top;
    p1 = ({32'd0, cfg_proc_noise} * {32'd0, dt}) >> 24;
    a  = ({32'd0, cfg_accel_noise} * {32'd0, dt}) >> 24;
    p2 = ({64'd0, a} * {96'd0, dt}) >> 24;
    if (p2 > 128'hFFFF_FFFF) p2 = 128'hFFFF_FFFF;
    pv = p1 + p2[63:0];
    if (pv > 64'hFFFF_FFFF) pv = 64'hFFFF_FFFF;
    for (int i = 0; i < 3; i++) begin
      v64 = est_vel[i];
      v64 = v64 + scale_by_dt($signed(rq.accel[i]), dt);
      est_vel[i] = sat_word(v64);
      nv = {32'd0, est_var[i]} + pv;
      if (nv > 64'hFFFF_FFFF) nv = 64'hFFFF_FFFF;
      if (nv == 64'd0) nv = 64'd1;
      est_var[i] = nv[31:0];
    end
  endfunction

  function automatic void update_step(filter_request_t rq);
    logic [63:0]        r, p, den, mag;
    logic [127:0]       corr, np;
    logic signed [63:0] diff, v64, c;
    r = {32'd0, rq.meas_noise};
    if (r == 64'd0) r = 64'd1;
    // first measurement just seeds the estimate
    if (!est_ready) begin
      reset_axes(1'b1, rq);
      est_ready = 1'b1;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      v64  = est_vel[i];
      diff = $signed(rq.meas[i]);
      diff = diff - v64;
      p    = (est_var[i] == 32'd0) ? 64'd1 : {32'd0, est_var[i]};
      den  = p + r;
      mag  = (diff < 0) ? -diff : diff;
      corr = ({64'd0, mag} * {64'd0, p}) / {64'd0, den};
      np   = ({64'd0, r} * {64'd0, p}) / {64'd0, den};
      c    = (diff < 0) ? -$signed(corr[63:0]) : $signed(corr[63:0]);
      est_vel[i] = sat_word(v64 + c);
      est_var[i] = (np == 128'd0) ? 32'd1 : np[31:0];
    end
  endfunction

  function automatic filter_state_t step_filter(filter_request_t rq);
    filter_state_t s;
    case (rq.command)
      CMD_PREDICT: predict_step(rq);
      CMD_UPDATE:  update_step(rq);
      CMD_CLEAR: begin
        reset_axes(1'b0, rq);
        est_ready = 1'b0;
      end
      CMD_LOAD: begin
        reset_axes(1'b1, rq);
        est_ready = 1'b1;
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      s.vel[i]      = est_vel[i];
      s.variance[i] = est_var[i];
    end
    s.initialized = est_ready;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic filter_request_t mk_req(cmd_e cmd, logic [31:0] ax, logic [31:0] ay,
                                            logic [31:0] az, logic [31:0] dt, logic [31:0] mx,
                                            logic [31:0] my, logic [31:0] mz, logic [31:0] r);
    filter_request_t rq;
    rq.command    = cmd;
    rq.accel      = {az, ay, ax};
    rq.step_time  = dt;
    rq.meas       = {mz, my, mx};
    rq.meas_noise = r;
    return rq;
  endfunction

  function automatic filter_state_t mk_state(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                             logic [31:0] p, logic init);
    filter_state_t s;
    s.vel         = {vz, vy, vx};
    s.variance    = {p, p, p};
    s.initialized = init;
    return s;
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0, 1: w = $urandom();
      2: begin
        w = $urandom_range(0, 32'h0040_0000);
        if ($urandom_range(0, 1) == 0) w = -w;
      end
      3: begin
        case ($urandom_range(0, 4))
          0: w = POS_MAX;
          1: w = NEG_MAX;
          2: w = 32'd0;
          3: w = ALL_ONES;
          default: w = 32'd1;
        endcase
      end
      4: w = UNIT_Q16 + $urandom_range(0, 255) - 128;
      default: w = $urandom() >> $urandom_range(0, 31);
    endcase
    return w;
  endfunction

  // measurement near the current estimate two times in three, so updates track a real signal
  function automatic logic [31:0] pick_meas(int axis);
    if ($urandom_range(0, 2) == 0) return pick_word();
    return est_vel[axis] + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
  endfunction

  function automatic logic [31:0] pick_step_time();
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1, 2:    return $urandom_range(0, DT_200MS);
      3:       return cfg_min_dt + $urandom_range(0, 2) - 1;
      default: return cfg_max_dt + $urandom_range(0, 2) - 1;
    endcase
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return $urandom();
      2:       return $urandom_range(1, 32'h0004_0000);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic filter_request_t random_request();
    int   roll;
    cmd_e cmd;
    roll = $urandom_range(0, 99);
    if (roll < 42)      cmd = CMD_PREDICT;
    else if (roll < 80) cmd = CMD_UPDATE;
    else if (roll < 90) cmd = CMD_LOAD;
    else                cmd = CMD_CLEAR;
    return mk_req(cmd, pick_word(), pick_word(), pick_word(), pick_step_time(),
                  pick_meas(0), pick_meas(1), pick_meas(2), pick_noise());
  endfunction

  // ---------------------------------------------------------------------------
  // Request channel
  // ---------------------------------------------------------------------------

  task automatic send_request(filter_request_t rq, bit typed, filter_state_t want);
    filter_state_t predicted;
    int            gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    command_i    <= rq.command;
    accel_x_i    <= rq.accel[0];
    accel_y_i    <= rq.accel[1];
    accel_z_i    <= rq.accel[2];
    step_time_i  <= rq.step_time;
    meas_x_i     <= rq.meas[0];
    meas_y_i     <= rq.meas[1];
    meas_z_i     <= rq.meas[2];
    meas_noise_i <= rq.meas_noise;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = step_filter(rq);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // drop valid and wait for every result to come back
  task automatic finish_phase();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_INIT_VAR: begin
        cfg_init_var = data;
        // variances follow the new value only until a velocity is held
        if (!est_ready)
          for (int i = 0; i < 3; i++) est_var[i] = floored_init_var();
      end
      REG_PROC_NOISE:  cfg_proc_noise  = data;
      REG_ACCEL_NOISE: cfg_accel_noise = data;
      REG_MIN_DT:      cfg_min_dt      = data;
      REG_MAX_DT:      cfg_max_dt      = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(int ph);
    logic [31:0] iv, pn, an, mn, mx;
    case (ph)
      0: begin iv = INIT_VAR_RST; pn = 0; an = 0; mn = 0; mx = MAX_DT_RST; end
      1: begin iv = 32'd0; pn = UNIT_Q16; an = UNIT_Q16; mn = 0; mx = MAX_DT_RST; end
      2: begin iv = ALL_ONES; pn = ALL_ONES; an = ALL_ONES; mn = 0; mx = ALL_ONES; end
      3: begin iv = 32'd1; pn = 32'd1; an = 32'd1; mn = ALL_ONES; mx = 32'd0; end
      // max below min: every dt above min is clipped to min
      4: begin iv = UNIT_Q16; pn = 32'd655; an = 32'd6554; mn = MAX_DT_RST; mx = 32'd100; end
      default: begin
        case ($urandom_range(0, 2))
          0:       iv = $urandom();
          1:       iv = $urandom_range(1, 32'h0010_0000);
          default: iv = 32'd0;
        endcase
        pn = $urandom() >> $urandom_range(0, 31);
        an = $urandom() >> $urandom_range(0, 31);
        mn = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(0, DT_50MS);
        mx = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, DT_200MS);
      end
    endcase
    write_reg(REG_INIT_VAR, iv);
    write_reg(REG_PROC_NOISE, pn);
    write_reg(REG_ACCEL_NOISE, an);
    write_reg(REG_MIN_DT, mn);
    write_reg(REG_MAX_DT, mx);
    // indexes past the last register must be ignored
    write_reg(REG_MAX_DT + CFG_IDX_W'($urandom_range(1, 3)), $urandom());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // receiver ready: random stall and run bursts, one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      next_ready = 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      next_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (calm) begin
      next_ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      next_ready = 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      next_ready = 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      next_ready = 1'b0;
    end else begin
      run_left   = $urandom_range(1, 40) - 1;
      next_ready = 1'b1;
    end
    out_ready_i <= next_ready;
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, vel_x", vel_x_o, 32'd0);
      end else begin
        popped_state = pending_results.pop_front();
        check_field("vel_x", vel_x_o, popped_state.vel[0]);
        check_field("vel_y", vel_y_o, popped_state.vel[1]);
        check_field("vel_z", vel_z_o, popped_state.vel[2]);
        check_field("var_x", var_x_o, popped_state.variance[0]);
        check_field("var_y", var_y_o, popped_state.variance[1]);
        check_field("var_z", var_z_o, popped_state.variance[2]);
        check_field("is_initialized", 32'(is_initialized_o), 32'(popped_state.initialized));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  task automatic build_directed_table();
    filter_state_t none;
    none = '0;
    directed_tab.push_back('{mk_req(CMD_CLEAR, 32'hDEAD_BEEF, 32'h1, 32'h2, ALL_ONES,
                             32'h3, 32'h4, 32'h5, 32'h6), 1'b1,
                             mk_state(0, 0, 0, INIT_VAR_RST, 1'b0)});
    // predict while uninitialized, dt far above the clip
    directed_tab.push_back('{mk_req(CMD_PREDICT, POS_MAX, NEG_MAX, UNIT_Q16, ALL_ONES,
                             0, 0, 0, 0), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_LOAD, 0, 0, 0, 0, POS_MAX, NEG_MAX, 0, 0), 1'b1,
                             mk_state(POS_MAX, NEG_MAX, 0, INIT_VAR_RST, 1'b1)});
    // velocities saturate on both ends
    directed_tab.push_back('{mk_req(CMD_PREDICT, POS_MAX, NEG_MAX, 0, ALL_ONES,
                             0, 0, 0, 0), 1'b1,
                             mk_state(POS_MAX, NEG_MAX, 0, INIT_VAR_RST, 1'b1)});
    // dt at the minimum is ignored
    directed_tab.push_back('{mk_req(CMD_PREDICT, NEG_MAX, POS_MAX, ALL_ONES, 0,
                             0, 0, 0, 0), 1'b1,
                             mk_state(POS_MAX, NEG_MAX, 0, INIT_VAR_RST, 1'b1)});
    directed_tab.push_back('{mk_req(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_UPDATE, 0, 0, 0, 0, NEG_MAX, POS_MAX, 32'h1234_5678,
                             ALL_ONES), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_UPDATE, 0, 0, 0, 0, POS_MAX, NEG_MAX, ALL_ONES,
                             UNIT_Q16), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_PREDICT, NEG_MAX, POS_MAX, 32'hFFFF_0000, DT_1S,
                             0, 0, 0, 0), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_PREDICT, POS_MAX, NEG_MAX, 32'd1, 32'd1,
                             0, 0, 0, 0), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_state(0, 0, 0, INIT_VAR_RST, 1'b0)});
    // update while uninitialized loads the measurement
    directed_tab.push_back('{mk_req(CMD_UPDATE, 0, 0, 0, 0, 32'h1234_5678, 32'h8765_4321, 0,
                             32'd5), 1'b1,
                             mk_state(32'h1234_5678, 32'h8765_4321, 0, INIT_VAR_RST, 1'b1)});
    directed_tab.push_back('{mk_req(CMD_LOAD, 0, 0, 0, 0, 0, ALL_ONES, 32'd1, 0), 1'b1,
                             mk_state(0, ALL_ONES, 32'd1, INIT_VAR_RST, 1'b1)});
    directed_tab.push_back('{mk_req(CMD_UPDATE, 0, 0, 0, 0, NEG_MAX, NEG_MAX, POS_MAX,
                             32'd1), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_PREDICT, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000,
                             MAX_DT_RST - 1, 0, 0, 0, 0), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_PREDICT, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000,
                             MAX_DT_RST, 0, 0, 0, 0), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_PREDICT, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000,
                             MAX_DT_RST + 1, 0, 0, 0, 0), 1'b0, none});
    directed_tab.push_back('{mk_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_state(0, 0, 0, INIT_VAR_RST, 1'b0)});
    // uninitialized predict with a too-short dt only clears
    directed_tab.push_back('{mk_req(CMD_PREDICT, POS_MAX, POS_MAX, POS_MAX, 0,
                             0, 0, 0, 0), 1'b1,
                             mk_state(0, 0, 0, INIT_VAR_RST, 1'b0)});
    directed_tab.push_back('{mk_req(CMD_UPDATE, 0, 0, 0, 0, POS_MAX, NEG_MAX, 32'd1,
                             ALL_ONES), 1'b1,
                             mk_state(POS_MAX, NEG_MAX, 32'd1, INIT_VAR_RST, 1'b1)});
    directed_tab.push_back('{mk_req(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
  endtask

  initial begin
    filter_request_t rq;
    filter_state_t   none;
    none = '0;

    // known levels from time zero
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_INIT_VAR;
    cfg_data_i   = 32'd0;
    in_valid_i   = 1'b0;
    command_i    = CMD_CLEAR;
    accel_x_i    = 32'd0;
    accel_y_i    = 32'd0;
    accel_z_i    = 32'd0;
    step_time_i  = 32'd0;
    meas_x_i     = 32'd0;
    meas_y_i     = 32'd0;
    meas_z_i     = 32'd0;
    meas_noise_i = 32'd0;
    out_ready_i  = 1'b0;

    // predictor starts from the reset state
    cfg_init_var    = INIT_VAR_RST;
    cfg_proc_noise  = 32'd0;
    cfg_accel_noise = 32'd0;
    cfg_min_dt      = 32'd0;
    cfg_max_dt      = MAX_DT_RST;
    for (int i = 0; i < 3; i++) begin
      est_vel[i] = 32'sd0;
      est_var[i] = INIT_VAR_RST;
    end
    est_ready = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed cases under the reset configuration
    build_directed_table();
    foreach (directed_tab[k])
      send_request(directed_tab[k].req, directed_tab[k].typed, directed_tab[k].want);
    finish_phase();

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      apply_settings(ph);
      if (ph == HOLD_PHASE) hold_request = 1'b1;
      if (ph == PHASES - 1) calm = 1'b1;
      repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, none);
      // leave the flag set or clear so the next starting-variance write sees both
      rq = random_request();
      rq.command = (ph % 2 == 0) ? CMD_CLEAR : CMD_LOAD;
      send_request(rq, 1'b0, none);
      finish_phase();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      popped_state = pending_results.pop_front();
      report_mismatch("missing result, vel_x", 32'd0, popped_state.vel[0]);
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
